// ----- hw/rtl/rcfd_pkg.sv -----
`default_nettype none

package rcfd_pkg;

  localparam int unsigned FrameBytes = 18;
  localparam int unsigned FillW      = $clog2(FrameBytes);
  localparam logic [FillW-1:0] LastFill = FillW'(FrameBytes - 1);

  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgDeadband = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTimeout  = CfgIdxW'(1);

  localparam logic [9:0]  DeadbandRst = 10'd0;
  localparam logic [31:0] TimeoutRst  = 32'd100;

  localparam logic [10:0] StickMin = 11'd364;
  localparam logic [10:0] StickMax = 11'd1684;
  localparam logic [15:0] StickMid = 16'd1024;
  localparam logic [15:0] Span     = 16'd660;
  localparam logic [14:0] QOne     = 15'd16384;
  // ceil(2^30 / 165): |v| * 16384 / 660 == (|v| * RecipMul) >> 18 for |v| < 660
  localparam logic [22:0] RecipMul = 23'd6507527;
  localparam int unsigned RecipShift = 18;

  localparam logic [2:0] AxisDial = 3'd4;

  typedef enum logic [1:0] {
    EvFrame   = 2'd0,
    EvReject  = 2'd1,
    EvOffline = 2'd2
  } event_e;

  typedef struct packed {
    event_e          kind;
    logic [3:0][10:0] stick;
    logic [15:0]     dial;
    logic [1:0]      rsw;
    logic [1:0]      lsw;
    logic [15:0]     mx;
    logic [15:0]     my;
    logic [15:0]     mz;
    logic [1:0]      btn;
    logic [15:0]     kbd;
  } rcfd_job_t;

  typedef struct packed {
    event_e      ev;
    logic [2:0]  idx;
    logic [15:0] val;
    logic [15:0] nrm;
    logic [1:0]  rsw;
    logic [1:0]  lsw;
    logic [15:0] mx;
    logic [15:0] my;
    logic [15:0] mz;
    logic [1:0]  btn;
    logic [15:0] kbd;
    logic        last;
  } rcfd_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcfd_ifs.sv -----
`default_nettype none

interface rcfd_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic [15:0] elapsed_ms;

  modport source (output valid, cmd, data_byte, elapsed_ms, input ready);
  modport sink   (input valid, cmd, data_byte, elapsed_ms, output ready);
endinterface

interface rcfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_res;
  logic [2:0]         axis_index;
  logic signed [15:0] axis_value;
  logic signed [15:0] axis_normalized;
  logic [1:0]         sw_right;
  logic [1:0]         sw_left;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic signed [15:0] mouse_z;
  logic [1:0]         mouse_buttons;
  logic [15:0]        keyboard;
  logic               last;

  modport source (
    output valid, event_res, axis_index, axis_value, axis_normalized, sw_right,
           sw_left, mouse_x, mouse_y, mouse_z, mouse_buttons, keyboard, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, axis_index, axis_value, axis_normalized, sw_right,
           sw_left, mouse_x, mouse_y, mouse_z, mouse_buttons, keyboard, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rcfd_cell.sv -----
`default_nettype none

module rcfd_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rcfd_emit.sv -----
`default_nettype none

module rcfd_emit import rcfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  rcfd_job_t  job_i,
  input  logic [9:0] deadband_i,
  output logic       busy_o,
  rcfd_out_if.source out_ch
);

  logic      job_vld_q, job_vld_d;
  rcfd_job_t job_q;
  logic [2:0] k_q, k_d;
  logic      out_vld_q, out_vld_d;
  rcfd_res_t res_q, res_d;

  logic        step, frame, done, dead, big;
  logic [15:0] sel, v, mag;
  logic [32:0] prod;
  logic [14:0] qm;
  logic [15:0] nrm;

  always_comb begin
    step  = job_vld_q && (!out_vld_q || out_ch.ready);
    frame = (job_q.kind == EvFrame);
    done  = !frame || (k_q == AxisDial);

    sel  = (k_q == AxisDial) ? job_q.dial : {5'b0, job_q.stick[k_q[1:0]]};
    v    = sel - StickMid;
    mag  = v[15] ? (~v + 16'd1) : v;
    dead = mag < {6'b0, deadband_i};
    big  = mag >= Span;
    prod = 33'(mag[9:0]) * 33'(RecipMul);
    qm   = big ? QOne : prod[RecipShift +: 15];
    nrm  = dead ? 16'd0 : (v[15] ? (~{1'b0, qm} + 16'd1) : {1'b0, qm});

    res_d      = '0;
    res_d.ev   = job_q.kind;
    res_d.last = done;
    if (frame) begin
      res_d.idx = k_q;
      res_d.val = dead ? 16'd0 : v;
      res_d.nrm = nrm;
      res_d.rsw = job_q.rsw;
      res_d.lsw = job_q.lsw;
      res_d.mx  = job_q.mx;
      res_d.my  = job_q.my;
      res_d.mz  = job_q.mz;
      res_d.btn = job_q.btn;
      res_d.kbd = job_q.kbd;
    end

    job_vld_d = job_vld_q;
    k_d       = k_q;
    if (load_i) begin
      job_vld_d = 1'b1;
      k_d       = 3'd0;
    end else if (step) begin
      if (done) begin
        job_vld_d = 1'b0;
      end else begin
        k_d = k_q + 3'd1;
      end
    end

    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      k_q       <= 3'd0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign busy_o                 = job_vld_q;
  assign out_ch.valid           = out_vld_q;
  assign out_ch.event_res       = res_q.ev;
  assign out_ch.axis_index      = res_q.idx;
  assign out_ch.axis_value      = res_q.val;
  assign out_ch.axis_normalized = res_q.nrm;
  assign out_ch.sw_right        = res_q.rsw;
  assign out_ch.sw_left         = res_q.lsw;
  assign out_ch.mouse_x         = res_q.mx;
  assign out_ch.mouse_y         = res_q.my;
  assign out_ch.mouse_z         = res_q.mz;
  assign out_ch.mouse_buttons   = res_q.btn;
  assign out_ch.keyboard        = res_q.kbd;
  assign out_ch.last            = res_q.last;

endmodule

`default_nettype wire

// ----- hw/rtl/rc_frame_resync_decoder_core.sv -----
// Channel   | Dir | Beat
// ----------+-----+-------------------------------------------------------
// in_ch     | in  | cmd, data_byte, elapsed_ms (byte or time tick)
// out_ch    | out | one decoded axis, reject or offline result, last flag
// cfg_*     | in  | register write: index, data
//
// The byte that completes the 18-byte window sets the check flag, then the emitter
// moves one result per cycle, unless the output stalls, into the output register:
// a frame result passes the check flag and job register, a timeout the job register.
// Input holds off in the check state and until the last result is registered.
// An output stall holds the emitter, a shared multiplier normalizing each axis.
// Reset clears fill count, online flag and handshake state; no clearing pass.
`default_nettype none

module rc_frame_resync_decoder_core import rcfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  rcfd_in_if.sink            in_ch,
  rcfd_out_if.source         out_ch
);

  logic [9:0]  deadband_q, deadband_d;
  logic [31:0] timeout_q, timeout_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic        chk_q, chk_d;
  logic        online_q, online_d;
  logic [31:0] since_q, since_d;

  logic        busy, acc, byte_acc, tick_acc, frame_ok, hit, load;
  logic [32:0] sum;
  logic [31:0] sat;
  logic [7:0]  win [FrameBytes];
  logic [3:0][10:0] stick;
  logic [1:0]  rsw, lsw;
  rcfd_job_t   job;

  for (genvar i = 0; i < FrameBytes; i++) begin : g_cell
    logic [7:0] nb;
    if (i == FrameBytes - 1) begin : g_tail
      assign nb = in_ch.data_byte;
    end else begin : g_body
      assign nb = win[i+1];
    end
    rcfd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (byte_acc),
      .byte_i  (nb),
      .byte_o  (win[i])
    );
  end

  assign stick[0] = {win[1][2:0], win[0]};
  assign stick[1] = {win[2][5:0], win[1][7:3]};
  assign stick[2] = {win[4][0], win[3], win[2][7:6]};
  assign stick[3] = {win[5][3:0], win[4][7:1]};
  assign rsw      = win[5][5:4];
  assign lsw      = win[5][7:6];

  always_comb begin
    frame_ok = (rsw != 2'd0) && (lsw != 2'd0);
    for (int k = 0; k < 4; k++) begin
      if (stick[k] < StickMin || stick[k] > StickMax) begin
        frame_ok = 1'b0;
      end
    end
  end

  assign in_ch.ready = !chk_q && !busy;
  assign acc         = in_ch.valid && in_ch.ready;
  assign byte_acc    = acc && !in_ch.cmd;
  assign tick_acc    = acc && in_ch.cmd;

  always_comb begin
    sum = {1'b0, since_q} + {17'b0, in_ch.elapsed_ms};
    sat = sum[32] ? '1 : sum[31:0];
    hit = tick_acc && online_q && (sat >= timeout_q);
  end

  always_comb begin
    deadband_d = deadband_q;
    timeout_d  = timeout_q;
    if (cfg_we_i && cfg_idx_i == CfgDeadband) begin
      deadband_d = cfg_wdata_i[9:0];
    end
    if (cfg_we_i && cfg_idx_i == CfgTimeout) begin
      timeout_d = cfg_wdata_i;
    end

    fill_d   = fill_q;
    chk_d    = 1'b0;
    online_d = online_q;
    since_d  = since_q;
    if (byte_acc) begin
      if (fill_q == LastFill) begin
        chk_d = 1'b1;
      end else begin
        fill_d = fill_q + FillW'(1);
      end
    end
    if (chk_q && frame_ok) begin
      fill_d   = '0;
      online_d = 1'b1;
      since_d  = '0;
    end
    if (tick_acc && online_q) begin
      since_d = sat;
      if (hit) begin
        online_d = 1'b0;
      end
    end
  end

  always_comb begin
    load       = chk_q || hit;
    job.kind   = chk_q ? (frame_ok ? EvFrame : EvReject) : EvOffline;
    job.stick  = stick;
    job.dial   = {win[17], win[16]};
    job.rsw    = rsw;
    job.lsw    = lsw;
    job.mx     = {win[7], win[6]};
    job.my     = {win[9], win[8]};
    job.mz     = {win[11], win[10]};
    job.btn    = {win[13] != 8'd0, win[12] != 8'd0};
    job.kbd    = {win[15], win[14]};
  end

  rcfd_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .job_i      (job),
    .deadband_i (deadband_q),
    .busy_o     (busy),
    .out_ch     (out_ch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DeadbandRst;
      timeout_q  <= TimeoutRst;
      fill_q     <= '0;
      chk_q      <= 1'b0;
      online_q   <= 1'b0;
      since_q    <= TimeoutRst;
    end else begin
      deadband_q <= deadband_d;
      timeout_q  <= timeout_d;
      fill_q     <= fill_d;
      chk_q      <= chk_d;
      online_q   <= online_d;
      since_q    <= since_d;
    end
  end

`ifndef SYNTHESIS
  a_online_from_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(online_q) |-> $past(chk_q))
    else $error("online set without a frame check");

  a_single_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.event_res != EvFrame) |-> (out_ch.last && out_ch.axis_index == 3'd0))
    else $error("reject or offline result not a single last beat");

  a_full_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_acc && fill_q == LastFill) |=> !in_ch.ready)
    else $error("input taken during frame check");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LastFill)
    else $error("fill count beyond window");
`endif

endmodule

`default_nettype wire
